// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the splitter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: hw/rtl/mlfs_pkg.sv
// Types and constants of the magic/length frame splitter.
package mlfs_pkg;

  localparam int POS_W     = 40;
  localparam int SIZE_W    = 32;
  localparam int MAGIC_W   = 32;
  localparam int SIZE_LEN  = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 40;

  localparam logic [MAGIC_W-1:0] MAGIC_RESET = 32'hD9B4BEF9;

  localparam logic [CFG_IDX_W-1:0] CFG_MAGIC_WORD   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_OFFSET = 2'd1;

  localparam logic KIND_HEADER  = 1'b0;
  localparam logic KIND_PAYLOAD = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [7:0]        payload_byte;
    logic [POS_W-1:0]  frame_offset;
    logic [SIZE_W-1:0] frame_size;
    logic              first_of_frame;
    logic              last_of_frame;
    logic              resynced;
    logic              truncated;
  } res_t;

endpackage

// File: hw/rtl/mlfs_parser.sv
// Front end: accepts stream bytes, tracks framing and builds result records.
`include "assert_macros.svh"

module mlfs_parser #(
  parameter int MAGIC_LEN = 4
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [7:0]                       in_data_byte,
  input  logic                             in_end_of_input,
  input  logic                             cfg_valid,
  input  logic [mlfs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mlfs_pkg::CFG_W-1:0]       cfg_data,
  input  logic                             q_space,
  output logic                             push,
  output mlfs_pkg::res_t                   push_res
);
  import mlfs_pkg::*;

  localparam int WIN_W  = 8 * MAGIC_LEN;
  localparam int CNT_MX = (MAGIC_LEN > SIZE_LEN) ? MAGIC_LEN : SIZE_LEN;
  localparam int CNT_W  = $clog2(CNT_MX + 1);
  localparam logic [CNT_W-1:0] ML_C = CNT_W'(MAGIC_LEN);
  localparam logic [CNT_W-1:0] SZ_C = CNT_W'(SIZE_LEN);

  typedef enum logic [1:0] {PH_MAGIC, PH_HUNT, PH_SIZE, PH_PAYLOAD} phase_t;

  phase_t             phase_r, phase_nxt;
  logic [WIN_W-1:0]   win_r, win_nxt;
  logic [CNT_W-1:0]   fc_r, fc_nxt;
  logic [SIZE_W-1:0]  size_r, size_nxt;
  logic [SIZE_W-1:0]  rem_r, rem_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [POS_W-1:0]   fs_r, fs_nxt;
  logic               hunt_r, hunt_nxt;
  logic [MAGIC_W-1:0] magic_r, magic_nxt;
  logic [POS_W-1:0]   start_r, start_nxt;

  logic               accept;
  logic [WIN_W-1:0]   win_sh;
  logic [WIN_W-1:0]   magic;
  logic [63:0]        magic_ext;
  logic [CNT_W-1:0]   fc_inc;
  logic [CNT_W-1:0]   fc_hunt;
  logic [SIZE_W-1:0]  size_new;
  logic [POS_W-1:0]   pos_inc;
  logic               done;
  logic               trunc;

  assign in_ready = q_space;
  assign accept   = in_valid && in_ready;

  assign win_sh    = (win_r >> 8) | (WIN_W'(in_data_byte) << (WIN_W - 8));
  assign magic_ext = 64'(magic_r);
  assign magic     = magic_ext[WIN_W-1:0];
  assign fc_inc    = fc_r + CNT_W'(1);
  assign fc_hunt   = (fc_r < ML_C) ? fc_inc : fc_r;
  assign size_new  = size_r | (SIZE_W'(in_data_byte) << {fc_r[1:0], 3'b000});
  assign pos_inc   = pos_r + POS_W'(1);
  assign done      = (rem_r <= SIZE_W'(1));
  assign trunc     = in_end_of_input && !done;

  always_comb begin
    phase_nxt = phase_r;
    win_nxt   = win_r;
    fc_nxt    = fc_r;
    size_nxt  = size_r;
    rem_nxt   = rem_r;
    pos_nxt   = pos_r;
    fs_nxt    = fs_r;
    hunt_nxt  = hunt_r;
    magic_nxt = magic_r;
    start_nxt = start_r;
    push      = 1'b0;
    push_res  = '0;
    push_res.frame_offset = fs_r;
    push_res.resynced     = hunt_r;

    if (accept) begin
      unique case (phase_r)
        PH_MAGIC: begin
          win_nxt = win_sh;
          fc_nxt  = fc_inc;
          if (fc_inc >= ML_C) begin
            fc_nxt  = '0;
            win_nxt = '0;
            if (win_sh == magic) begin
              phase_nxt = PH_SIZE;
              size_nxt  = '0;
            end else begin
              phase_nxt = PH_HUNT;
              hunt_nxt  = 1'b1;
            end
          end
        end
        PH_HUNT: begin
          win_nxt = win_sh;
          fc_nxt  = fc_hunt;
          if (fc_hunt >= ML_C && win_sh == magic) begin
            phase_nxt = PH_SIZE;
            fc_nxt    = '0;
            win_nxt   = '0;
            size_nxt  = '0;
          end
        end
        PH_SIZE: begin
          size_nxt = size_new;
          fc_nxt   = fc_inc;
          if (fc_inc >= SZ_C) begin
            fc_nxt  = '0;
            rem_nxt = size_new;
            push    = 1'b1;
            push_res.kind       = KIND_HEADER;
            push_res.frame_size = size_new;
            if (size_new == '0) begin
              push_res.last_of_frame = 1'b1;
              phase_nxt = PH_MAGIC;
              win_nxt   = '0;
              hunt_nxt  = 1'b0;
              fs_nxt    = pos_inc;
            end else if (in_end_of_input) begin
              push_res.last_of_frame = 1'b1;
              push_res.truncated     = 1'b1;
            end else begin
              phase_nxt = PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          push = 1'b1;
          push_res.kind           = KIND_PAYLOAD;
          push_res.payload_byte   = in_data_byte;
          push_res.frame_size     = size_r;
          push_res.first_of_frame = (rem_r == size_r);
          push_res.last_of_frame  = done || trunc;
          push_res.truncated      = trunc;
          if (rem_r != '0) rem_nxt = rem_r - SIZE_W'(1);
          if (done) begin
            phase_nxt = PH_MAGIC;
            fc_nxt    = '0;
            win_nxt   = '0;
            hunt_nxt  = 1'b0;
            fs_nxt    = pos_inc;
          end
        end
        default: phase_nxt = PH_MAGIC;
      endcase

      if (in_end_of_input) begin
        // new stream starts with the next byte
        phase_nxt = PH_MAGIC;
        win_nxt   = '0;
        fc_nxt    = '0;
        size_nxt  = '0;
        rem_nxt   = '0;
        hunt_nxt  = 1'b0;
        pos_nxt   = start_r;
        fs_nxt    = start_r;
      end else begin
        pos_nxt = pos_inc;
      end
    end

    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_MAGIC_WORD:   magic_nxt = cfg_data[MAGIC_W-1:0];
        CFG_START_OFFSET: begin
          start_nxt = cfg_data[POS_W-1:0];
          pos_nxt   = cfg_data[POS_W-1:0];
          fs_nxt    = cfg_data[POS_W-1:0];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_MAGIC;
      win_r   <= '0;
      fc_r    <= '0;
      size_r  <= '0;
      rem_r   <= '0;
      pos_r   <= '0;
      fs_r    <= '0;
      hunt_r  <= 1'b0;
      magic_r <= MAGIC_RESET;
      start_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      win_r   <= win_nxt;
      fc_r    <= fc_nxt;
      size_r  <= size_nxt;
      rem_r   <= rem_nxt;
      pos_r   <= pos_nxt;
      fs_r    <= fs_nxt;
      hunt_r  <= hunt_nxt;
      magic_r <= magic_nxt;
      start_r <= start_nxt;
    end
  end

  `ASSERT_RST(a_payload_rem, (phase_r == PH_PAYLOAD) |-> (rem_r != '0), "payload with no bytes left")
  `ASSERT_RST(a_size_cnt, (phase_r == PH_SIZE) |-> (fc_r < SZ_C), "size byte counter overrun")

endmodule

// File: hw/rtl/mlfs_queue.sv
// Short result queue between parser and output stage.
`include "assert_macros.svh"

module mlfs_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  mlfs_pkg::res_t push_res,
  output logic           space,
  input  logic           pop,
  output logic           empty,
  output mlfs_pkg::res_t head
);
  import mlfs_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_P = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_C = CNT_W'(DEPTH);

  res_t             mem [DEPTH];
  logic [PTR_W-1:0] wp_r, wp_nxt;
  logic [PTR_W-1:0] rp_r, rp_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign space = (cnt_r != FULL_C);
  assign empty = (cnt_r == '0);
  assign head  = mem[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) wp_nxt = (wp_r == LAST_P) ? '0 : wp_r + PTR_W'(1);
    if (pop)  rp_nxt = (rp_r == LAST_P) ? '0 : rp_r + PTR_W'(1);
    if (push && !pop) cnt_nxt = cnt_r + CNT_W'(1);
    else if (pop && !push) cnt_nxt = cnt_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (push) mem[wp_r] <= push_res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  `ASSERT_RST(a_no_overflow, push |-> (space || pop), "push into full queue")
  `ASSERT_RST(a_cnt_up, (push && !pop) |=> (cnt_r == $past(cnt_r) + CNT_W'(1)), "count lost a push")

endmodule

// File: hw/rtl/mlfs_out_stage.sv
// Back end: output register that hands results to the consumer.
`include "assert_macros.svh"

module mlfs_out_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  mlfs_pkg::res_t q_head,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output mlfs_pkg::res_t out_res
);
  import mlfs_pkg::*;

  logic valid_r, valid_nxt;
  res_t data_r;

  assign pop       = !q_empty && (!valid_r || out_ready);
  assign valid_nxt = pop || (valid_r && !out_ready);
  assign out_valid = valid_r;
  assign out_res   = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else        valid_r <= valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (pop) data_r <= q_head;
  end

  `ASSERT_RST(a_pop_nonempty, pop |-> !q_empty, "pop from empty queue")

endmodule

// File: hw/rtl/magic_length_frame_splitter.sv
// Top level of the magic/length frame splitter.
// Byte-stream deframer: each record is a MAGIC_LEN-byte magic word, a 4-byte
// little-endian size and that many payload bytes. One byte is taken per clock
// for as long as the result side keeps up; a header transaction follows the
// last size byte and one payload transaction follows each payload byte. A
// byte's result is written into the result queue at the edge that accepts the
// byte and is loaded into the output register, which drives out_valid, once
// that register is empty or being taken. in_ready drops only when the result
// queue of FIFO_DEPTH entries is full, which only builds up while out_ready is
// held low; the queue depth sets how long the consumer may stall before input
// backs up. A magic mismatch drops those bytes and starts a sliding-window hunt;
// the next frame found that way carries resynced. A byte with end_of_input
// ends the stream: a frame cut after its size field carries truncated, and
// the framing state resets, with both positions loaded from start_offset.
// Configuration writes (index 0 magic_word, 1 start_offset, others ignored)
// are always ready and are meant for idle periods; writing start_offset also
// seeks the current position. No clearing pass is needed after reset.
module magic_length_frame_splitter #(
  parameter int MAGIC_LEN  = 4,
  parameter int FIFO_DEPTH = 4
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [7:0]                       in_data_byte,
  input  logic                             in_end_of_input,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_kind,
  output logic [7:0]                       out_payload_byte,
  output logic [mlfs_pkg::POS_W-1:0]       out_frame_offset,
  output logic [mlfs_pkg::SIZE_W-1:0]      out_frame_size,
  output logic                             out_first_of_frame,
  output logic                             out_last_of_frame,
  output logic                             out_resynced,
  output logic                             out_truncated,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [mlfs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mlfs_pkg::CFG_W-1:0]       cfg_data
);
  import mlfs_pkg::*;

  logic q_space;
  logic q_empty;
  logic push;
  logic pop;
  res_t push_res;
  res_t q_head;
  res_t out_res;

  // registers are plain flops, so writes never stall
  assign cfg_ready = 1'b1;

  mlfs_parser #(.MAGIC_LEN(MAGIC_LEN)) u_parser (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_byte    (in_data_byte),
    .in_end_of_input (in_end_of_input),
    .cfg_valid       (cfg_valid),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .q_space         (q_space),
    .push            (push),
    .push_res        (push_res)
  );

  // decouples the parser from output stalls
  mlfs_queue #(.DEPTH(FIFO_DEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_res (push_res),
    .space    (q_space),
    .pop      (pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  mlfs_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_kind           = out_res.kind;
  assign out_payload_byte   = out_res.payload_byte;
  assign out_frame_offset   = out_res.frame_offset;
  assign out_frame_size     = out_res.frame_size;
  assign out_first_of_frame = out_res.first_of_frame;
  assign out_last_of_frame  = out_res.last_of_frame;
  assign out_resynced       = out_res.resynced;
  assign out_truncated      = out_res.truncated;

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench for the magic/length frame splitter.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mlfs_pkg::*;

  // Codes the block accepts on cfg_index but ignores.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

  localparam int MAGIC_BYTES   = 4;
  localparam int SETTLE_CYCLES = 8;      // queue write + output reg + margin
  localparam int CYCLE_LIMIT   = 400000; // slowest legal run is far below this

  typedef enum logic [1:0] {
    SEEK_MAGIC,
    HUNT_MAGIC,
    READ_SIZE,
    READ_PAYLOAD
  } dfr_phase_e;

  typedef struct {
    logic [7:0] data;
    logic       eoi;
    bit         hold;    // wait for all outstanding results before presenting
  } feed_item_t;

  // ---------------------------------------------------------------------------
  // DUT connections
  // ---------------------------------------------------------------------------
  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [7:0]           in_data_byte = 8'h00;
  logic                 in_end_of_input = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 out_kind;
  logic [7:0]           out_payload_byte;
  logic [POS_W-1:0]     out_frame_offset;
  logic [SIZE_W-1:0]    out_frame_size;
  logic                 out_first_of_frame;
  logic                 out_last_of_frame;
  logic                 out_resynced;
  logic                 out_truncated;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  magic_length_frame_splitter uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_data_byte       (in_data_byte),
    .in_end_of_input    (in_end_of_input),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_kind           (out_kind),
    .out_payload_byte   (out_payload_byte),
    .out_frame_offset   (out_frame_offset),
    .out_frame_size     (out_frame_size),
    .out_first_of_frame (out_first_of_frame),
    .out_last_of_frame  (out_last_of_frame),
    .out_resynced       (out_resynced),
    .out_truncated      (out_truncated),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Bookkeeping
  // ---------------------------------------------------------------------------
  feed_item_t byte_feed[$];         // bytes waiting for the driver
  res_t       expected_results[$];  // predicted results, oldest first
  int         bytes_queued = 0;
  int         bytes_accepted = 0;
  int         err_count = 0;
  int         cycle_count = 0;
  int         n_headers = 0, n_payload = 0, n_resync = 0, n_trunc = 0, n_cfg = 0;
  int         send_idle_pct = 0, recv_idle_pct = 0;
  bit         hold_next = 1'b0;

  // Shadow of the deframer: configuration and stream state.
  logic [MAGIC_W-1:0] magic_cfg;
  logic [POS_W-1:0]   start_cfg;
  dfr_phase_e         dfr_phase;
  logic [31:0]        dfr_window;
  int                 dfr_count;
  logic [SIZE_W-1:0]  dfr_size;
  logic [SIZE_W-1:0]  dfr_left;
  logic [POS_W-1:0]   dfr_pos;
  logic [POS_W-1:0]   dfr_fstart;
  logic               dfr_hunted;

  // ---------------------------------------------------------------------------
  // Clock and cycle counter
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("%0t ns: timeout, %0d results still outstanding", $time,
             expected_results.size());
    $display("[FAIL] regression broken");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Deframer predictor
  // ---------------------------------------------------------------------------
  // Stream restart: everything back to post-reset, positions from start_cfg.
  function automatic void restart_stream();
    dfr_phase  = SEEK_MAGIC;
    dfr_window = '0;
    dfr_count  = 0;
    dfr_size   = '0;
    dfr_left   = '0;
    dfr_hunted = 1'b0;
    dfr_pos    = start_cfg;
    dfr_fstart = start_cfg;
  endfunction

  // Frame boundary: next frame's offset is the byte after this one.
  function automatic void close_frame();
    dfr_phase  = SEEK_MAGIC;
    dfr_count  = 0;
    dfr_window = '0;
    dfr_hunted = 1'b0;
    dfr_fstart = dfr_pos + 1'b1;
  endfunction

  function automatic void note_result(input logic kind, input logic [7:0] b,
                                      input logic first, input logic last,
                                      input logic trunc);
    res_t r;
    r.kind           = kind;
    r.payload_byte   = b;
    r.frame_offset   = dfr_fstart;
    r.frame_size     = dfr_size;
    r.first_of_frame = first;
    r.last_of_frame  = last;
    r.resynced       = dfr_hunted;
    r.truncated      = trunc;
    expected_results = {expected_results, r};
  endfunction

  // One accepted byte: advance the shadow state, queue any result it causes.
  function automatic void deframe_byte(input logic [7:0] b, input logic eoi);
    logic first, done, trunc;
    case (dfr_phase)
      SEEK_MAGIC: begin
        dfr_window = {b, dfr_window[31:8]};
        dfr_count++;
        if (dfr_count >= MAGIC_BYTES) begin
          dfr_count = 0;
          if (dfr_window == magic_cfg) begin
            dfr_phase = READ_SIZE;
            dfr_size  = '0;
          end else begin
            // wrong bytes in magic position: drop them, go hunting
            dfr_phase  = HUNT_MAGIC;
            dfr_hunted = 1'b1;
          end
          dfr_window = '0;
        end
      end
      HUNT_MAGIC: begin
        dfr_window = {b, dfr_window[31:8]};
        if (dfr_count < MAGIC_BYTES) dfr_count++;
        if (dfr_count >= MAGIC_BYTES && dfr_window == magic_cfg) begin
          dfr_phase  = READ_SIZE;
          dfr_count  = 0;
          dfr_window = '0;
          dfr_size   = '0;
        end
      end
      READ_SIZE: begin
        dfr_size = dfr_size | (32'(b) << (8 * dfr_count));
        dfr_count++;
        if (dfr_count >= SIZE_LEN) begin
          dfr_count = 0;
          dfr_left  = dfr_size;
          if (dfr_size == '0) begin
            note_result(KIND_HEADER, 8'h00, 1'b0, 1'b1, 1'b0);
            close_frame();
          end else if (eoi) begin
            // stream cut right after the size field
            note_result(KIND_HEADER, 8'h00, 1'b0, 1'b1, 1'b1);
          end else begin
            note_result(KIND_HEADER, 8'h00, 1'b0, 1'b0, 1'b0);
            dfr_phase = READ_PAYLOAD;
          end
        end
      end
      default: begin
        first = (dfr_left == dfr_size);
        done  = (dfr_left <= 1);
        trunc = eoi && !done;
        note_result(KIND_PAYLOAD, b, first, done | trunc, trunc);
        if (dfr_left > 0) dfr_left = dfr_left - 1'b1;
        if (done) close_frame();
      end
    endcase
    if (eoi) restart_stream();
    else dfr_pos = dfr_pos + 1'b1;   // 40-bit wrap is natural here
  endfunction

  // ---------------------------------------------------------------------------
  // Input driver: presents queued bytes, predicts on every accepted transaction
  // ---------------------------------------------------------------------------
  int s_calm = 0;

  always @(posedge clk) begin : byte_driver
    feed_item_t nxt;
    bit         go;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        deframe_byte(in_data_byte, in_end_of_input);
        bytes_accepted++;
      end
      // Random stretches without sender idling.
      if (s_calm > 0) s_calm--;
      else if ($urandom_range(0, 99) < 2) s_calm = $urandom_range(10, 40);
      // Slot is free when nothing is held or the held byte just went in.
      if (!in_valid || in_ready) begin
        go = byte_feed.size() != 0;
        if (go && byte_feed[0].hold && expected_results.size() != 0) go = 1'b0;
        if (go && s_calm == 0 && $urandom_range(0, 99) < send_idle_pct) go = 1'b0;
        if (go) begin
          nxt = byte_feed.pop_front();
          in_data_byte    <= nxt.data;
          in_end_of_input <= nxt.eoi;
          in_valid        <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output monitor: compares each result transaction with the oldest prediction
  // ---------------------------------------------------------------------------
  function automatic bit field_ok(input string name, input logic [63:0] want,
                                  input logic [63:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name,
               want, got);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  int r_calm = 0;

  always @(posedge clk) begin : result_monitor
    res_t want;
    bit   ok;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, actual kind %0h byte %0h",
                   $time, out_kind, out_payload_byte);
          err_count++;
        end else begin
          want = expected_results.pop_front();
          ok = 1'b1;
          ok &= field_ok("kind", want.kind, out_kind);
          ok &= field_ok("payload_byte", want.payload_byte, out_payload_byte);
          ok &= field_ok("frame_offset", want.frame_offset, out_frame_offset);
          ok &= field_ok("frame_size", want.frame_size, out_frame_size);
          ok &= field_ok("first_of_frame", want.first_of_frame, out_first_of_frame);
          ok &= field_ok("last_of_frame", want.last_of_frame, out_last_of_frame);
          ok &= field_ok("resynced", want.resynced, out_resynced);
          ok &= field_ok("truncated", want.truncated, out_truncated);
          if (!ok) err_count++;
          if (want.kind == KIND_HEADER) n_headers++;
          else n_payload++;
          if (want.resynced) n_resync++;
          if (want.truncated) n_trunc++;
        end
      end
      if (r_calm > 0) r_calm--;
      else if ($urandom_range(0, 99) < 2) r_calm = $urandom_range(10, 40);
      out_ready <= (r_calm != 0) || ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_byte(input logic [7:0] b, input logic eoi);
    feed_item_t it;
    it.data = b;
    it.eoi  = eoi;
    it.hold = hold_next;
    hold_next = 1'b0;
    byte_feed = {byte_feed, it};
    bytes_queued++;
  endtask

  task automatic push_word(input logic [31:0] w, input bit eoi_last);
    for (int k = 0; k < 4; k++) push_byte(w[8*k +: 8], eoi_last && k == 3);
  endtask

  // Well-formed frame. stop < 0: stream goes on; stop == 0: stream ends on the
  // last size byte; stop > 0: stream ends on payload byte number stop.
  task automatic push_frame(input logic [31:0] len, input int stop);
    int n;
    push_word(magic_cfg, 1'b0);
    push_word(len, stop == 0);
    n = (stop < 0) ? int'(len) : stop;
    for (int i = 1; i <= n; i++) push_byte(8'($urandom), stop > 0 && i == n);
  endtask

  // Waits until every queued byte is in and every result is out, then lets
  // the pipeline drain bytes that produce no result.
  task automatic settle();
    while (bytes_accepted != bytes_queued || expected_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    n_cfg++;
    if (idx == CFG_MAGIC_WORD) begin
      magic_cfg = val[MAGIC_W-1:0];
    end else if (idx == CFG_START_OFFSET) begin
      // a start_offset write is also a seek
      start_cfg  = val[POS_W-1:0];
      dfr_pos    = start_cfg;
      dfr_fstart = start_cfg;
    end
  endtask

  // Mostly good frames with random content; the rest is broken magic,
  // truncation, streams that end inside a field, and loose noise.
  task automatic random_traffic(input int n_bytes);
    int          goal, pick, nb;
    logic [31:0] len, w;
    goal = bytes_queued + n_bytes;
    while (bytes_queued < goal) begin
      if ($urandom_range(0, 99) < 3) hold_next = 1'b1;
      pick = $urandom_range(0, 99);
      len  = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 8) : $urandom_range(9, 40);
      if (pick < 62) begin
        if ($urandom_range(0, 99) < 12) push_frame(len, int'(len));
        else push_frame(len, -1);
      end else if (pick < 74) begin
        w = magic_cfg ^ $urandom_range(1, 32'hFFFF_FFFF);
        push_word(w, 1'b0);
        nb = $urandom_range(0, 5);
        repeat (nb) push_byte(8'($urandom), 1'b0);
        push_frame(len, -1);
      end else if (pick < 84) begin
        len = $urandom;
        if (len < 8) len = len + 8;
        push_frame(len, $urandom_range(0, 5));
      end else if (pick < 92) begin
        // stream ends before the header is complete
        nb = $urandom_range(1, 7);
        w  = $urandom;
        for (int i = 0; i < nb; i++) begin
          if ($urandom_range(0, 1) == 0)
            push_byte((i < 4) ? magic_cfg[8*i +: 8] : w[8*(i-4) +: 8], i == nb - 1);
          else
            push_byte(8'($urandom), i == nb - 1);
        end
      end else begin
        nb = $urandom_range(1, 6);
        repeat (nb) push_byte(8'($urandom), 1'b0);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    magic_cfg = MAGIC_RESET;
    start_cfg = '0;
    restart_stream();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed, reset configuration.
    send_idle_pct = 11;
    recv_idle_pct = 54;
    // magic off by one byte, then a zero-size frame found by hunting
    push_word({8'h00, MAGIC_RESET[23:0]}, 1'b0);
    push_frame(32'd0, -1);
    // all-ones size, stream ends two payload bytes in
    push_word(MAGIC_RESET, 1'b0);
    push_word(32'hFFFF_FFFF, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b1);
    // stream ends inside the magic field: no result
    push_byte(MAGIC_RESET[7:0], 1'b0);
    push_byte(MAGIC_RESET[15:8], 1'b1);
    settle();

    // All-ones magic, offset just below the 40-bit wrap.
    cfg_write(CFG_MAGIC_WORD, {8'hA5, 32'hFFFF_FFFF});
    cfg_write(CFG_START_OFFSET, 40'hFF_FFFF_FFEC);
    cfg_write(CFG_SPARE_2, {8'($urandom), 32'($urandom)});
    hold_next = 1'b1;
    random_traffic(256);
    settle();

    // Zero magic, random offset; receiver now mostly ready, sender idles.
    send_idle_pct = 54;
    recv_idle_pct = 11;
    cfg_write(CFG_MAGIC_WORD, 40'h0);
    cfg_write(CFG_START_OFFSET, {8'($urandom), 32'($urandom)});
    cfg_write(CFG_SPARE_3, {8'($urandom), 32'($urandom)});
    random_traffic(256);
    settle();

    // Back-to-back: random magic, maximum offset.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    cfg_write(CFG_MAGIC_WORD, {8'h00, 32'($urandom)});
    cfg_write(CFG_START_OFFSET, 40'hFF_FFFF_FFFF);
    random_traffic(256);
    settle();

    // Back-to-back: reset magic, zero offset.
    cfg_write(CFG_MAGIC_WORD, {8'h00, MAGIC_RESET});
    cfg_write(CFG_START_OFFSET, 40'h0);
    random_traffic(256);

    settle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      $display("%0t ns: %0d results never arrived, expected %0d, actual 0", $time,
               expected_results.size(), expected_results.size());
      err_count++;
    end
    $display("Covered %0d bytes in, %0d headers and %0d payload bytes out, %0d config writes",
             bytes_accepted, n_headers, n_payload, n_cfg);
    $display("  %0d resynced and %0d truncated results, %0d mismatching transactions",
             n_resync, n_trunc, err_count);
    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: magic_length_frame_splitter.f
+incdir+hw/rtl
hw/rtl/mlfs_pkg.sv
hw/rtl/mlfs_parser.sv
hw/rtl/mlfs_queue.sv
hw/rtl/mlfs_out_stage.sv
hw/rtl/magic_length_frame_splitter.sv
tb/sv/tb_top.sv
